[sv/dmm_pkg.sv]
// shared types, codes and sizes for the dense matrix multiply core
package dmm_pkg;

  localparam int MAX_DIM_DEFAULT = 16;
  localparam int IDX_REACH       = 16;
  localparam int IDX_W           = 4;
  localparam int DIM_W           = 5;
  localparam int VAL_W           = 32;
  localparam int CMD_DEPTH       = 4;
  localparam int RES_DEPTH       = 4;

  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_ROW    = 2'd2;

  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(16);

  typedef enum logic [1:0] {
    OP_LOAD_A,
    OP_LOAD_B,
    OP_ROW,
    OP_ERR
  } op_t;

  typedef struct packed {
    logic [DIM_W-1:0] nr;
    logic [DIM_W-1:0] nk;
    logic [DIM_W-1:0] nc;
  } dims_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             last;
    logic             err;
  } res_t;

endpackage

[sv/dmm_fifo.sv]
// small synchronous fifo used for the command and result queues
module dmm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] din,
  input  logic         rd,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CNT_W'(wr) - CNT_W'(rd);
    end
  end

endmodule

[sv/dmm_front.sv]
// front end: size registers, index checks and command classification
module dmm_front #(
  parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [4:0]            cfg_data,
  input  logic                  push,
  input  logic [1:0]            func,
  input  logic [3:0]            row_index,
  input  logic [3:0]            col_index,
  input  logic signed [31:0]    element_value,
  input  logic                  cmd_full,
  output logic                  cmd_push,
  output dmm_pkg::cmd_t         cmd,
  output dmm_pkg::dims_t        dims
);
  import dmm_pkg::*;

  localparam int EFF_CAP = (MAX_DIM < IDX_REACH) ? MAX_DIM : IDX_REACH;

  logic [DIM_W-1:0] rows_a;
  logic [DIM_W-1:0] inner_dim;
  logic [DIM_W-1:0] cols_b;
  logic [DIM_W-1:0] row_ext;
  logic [DIM_W-1:0] col_ext;
  logic             keep;

  function automatic logic [DIM_W-1:0] eff(input logic [DIM_W-1:0] v);
    return (v > DIM_W'(EFF_CAP)) ? DIM_W'(EFF_CAP) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_RESET;
      inner_dim <= DIM_RESET;
      cols_b    <= DIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROWS_A:    rows_a    <= cfg_data;
        REG_INNER_DIM: inner_dim <= cfg_data;
        REG_COLS_B:    cols_b    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dims.nr = eff(rows_a);
  assign dims.nk = eff(inner_dim);
  assign dims.nc = eff(cols_b);

  assign row_ext = DIM_W'(row_index);
  assign col_ext = DIM_W'(col_index);

  always_comb begin
    keep      = 1'b1;
    cmd.row   = row_index;
    cmd.col   = col_index;
    cmd.value = element_value;
    cmd.op    = OP_ERR;
    case (func)
      FUNC_LOAD_A: begin
        cmd.op = (row_ext >= dims.nr || col_ext >= dims.nk) ? OP_ERR : OP_LOAD_A;
      end
      FUNC_LOAD_B: begin
        cmd.op = (row_ext >= dims.nk || col_ext >= dims.nc) ? OP_ERR : OP_LOAD_B;
      end
      FUNC_ROW: begin
        cmd.op = (row_ext >= dims.nr || dims.nc == '0) ? OP_ERR : OP_ROW;
      end
      default: begin
        // unused code is taken and dropped
        keep = 1'b0;
      end
    endcase
  end

  assign cmd_push = push && !cmd_full && keep;

endmodule

[sv/dmm_back.sv]
// back end: element stores, row sequencer and multiply-accumulate pipeline
module dmm_back #(
  parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  dmm_pkg::dims_t dims,
  input  dmm_pkg::cmd_t  cmd,
  input  logic           cmd_empty,
  output logic           cmd_pop,
  output logic           res_push,
  output dmm_pkg::res_t  res,
  input  logic           res_pop
);
  import dmm_pkg::*;

  localparam int EFF_CAP   = (MAX_DIM < IDX_REACH) ? MAX_DIM : IDX_REACH;
  localparam int IW        = $clog2(MAX_DIM);
  localparam int KW        = (EFF_CAP > 1) ? $clog2(EFF_CAP) : 1;
  localparam int AW        = 2 * IW;
  // row and column bits are concatenated, so the store spans the full address range
  localparam int MEM_DEPTH = 1 << AW;
  localparam int PW        = $clog2(RES_DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_ROW
  } state_t;

  typedef struct packed {
    logic             first;
    logic             last;
    logic             kill;
    logic             err;
    logic             eor;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } slot_t;

  logic [VAL_W-1:0] a_mem [MEM_DEPTH];
  logic [VAL_W-1:0] b_mem [MEM_DEPTH];

  state_t           state;
  logic [IDX_W-1:0] cur_row;
  logic [KW-1:0]    j;
  logic [KW-1:0]    k;
  logic [PW-1:0]    pending;

  logic             credit_ok;
  logic             k_last;
  logic             j_last;
  logic             issue;
  slot_t            slot;
  logic [AW-1:0]    addr_a;
  logic [AW-1:0]    addr_b;
  logic [AW-1:0]    addr_w;

  logic signed [VAL_W-1:0] a_q;
  logic signed [VAL_W-1:0] b_q;
  logic signed [63:0]      prod;
  logic signed [63:0]      acc;
  slot_t                   s1;
  slot_t                   s2;
  slot_t                   s3;
  logic                    s1_valid;
  logic                    s2_valid;
  logic                    s3_valid;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                 input logic signed [63:0] y);
    logic signed [64:0] s;
    s = {x[63], x} + {y[63], y};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  // round half up to q16.16, then clamp to 32 bits
  function automatic logic [VAL_W-1:0] round_sat(input logic signed [63:0] x);
    logic signed [48:0] q;
    q = $signed({x[63], x[63:16]}) + $signed({48'b0, x[15]});
    if (q > 49'sd2147483647) begin
      return 32'h7fff_ffff;
    end
    if (q < -49'sd2147483648) begin
      return 32'h8000_0000;
    end
    return q[31:0];
  endfunction

  assign credit_ok = (pending < PW'(RES_DEPTH));
  assign k_last    = (dims.nk == '0) || (DIM_W'(k) == dims.nk - DIM_W'(1));
  assign j_last    = (DIM_W'(j) == dims.nc - DIM_W'(1));

  always_comb begin
    issue      = 1'b0;
    cmd_pop    = 1'b0;
    slot.first = (k == '0);
    slot.last  = k_last;
    slot.kill  = (dims.nk == '0);
    slot.err   = 1'b0;
    slot.eor   = j_last;
    slot.row   = cur_row;
    slot.col   = IDX_W'(j);
    case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          case (cmd.op)
            OP_ERR: begin
              if (credit_ok) begin
                cmd_pop    = 1'b1;
                issue      = 1'b1;
                slot.first = 1'b1;
                slot.last  = 1'b1;
                slot.kill  = 1'b1;
                slot.err   = 1'b1;
                slot.eor   = 1'b1;
                slot.row   = cmd.row;
                slot.col   = cmd.col;
              end
            end
            default: cmd_pop = 1'b1;
          endcase
        end
      end
      ST_ROW: begin
        // a new element needs a free result slot; later products follow freely
        issue = (k != '0) || credit_ok;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pending <= '0;
      j       <= '0;
      k       <= '0;
    end else begin
      pending <= pending + PW'(issue && slot.first) - PW'(res_pop);
      case (state)
        ST_IDLE: begin
          if (cmd_pop && cmd.op == OP_ROW) begin
            state   <= ST_ROW;
            cur_row <= cmd.row;
            j       <= '0;
            k       <= '0;
          end
        end
        ST_ROW: begin
          if (issue) begin
            if (k_last) begin
              k <= '0;
              if (j_last) begin
                state <= ST_IDLE;
              end else begin
                j <= j + 1'b1;
              end
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign addr_a = {IW'(cur_row), IW'(k)};
  assign addr_b = {IW'(k), IW'(j)};
  assign addr_w = {IW'(cmd.row), IW'(cmd.col)};

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.op == OP_LOAD_A) begin
      a_mem[addr_w] <= cmd.value;
    end
    a_q <= a_mem[addr_a];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.op == OP_LOAD_B) begin
      b_mem[addr_w] <= cmd.value;
    end
    b_q <= b_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid && s2.last;
    end
    s1   <= slot;
    s2   <= s1;
    s3   <= s2;
    prod <= s1.kill ? 64'sd0 : a_q * b_q;
    if (s2_valid) begin
      acc <= s2.first ? prod : sat_add(acc, prod);
    end
  end

  assign res_push  = s3_valid;
  assign res.row   = s3.row;
  assign res.col   = s3.col;
  assign res.value = round_sat(acc);
  assign res.last  = s3.eor;
  assign res.err   = s3.err;

endmodule

[sv/dense_matrix_multiply_core.sv]
// Dense matrix product core in signed Q16.16. Load items write one element of A or B in the back
// end; an index out of range gives one error beat. A compute item yields the cols_b elements
// of one result row, in column order, with the last beat marked. The single multiply-accumulate
// unit takes one product per cycle while a result slot is free for each new element; the 32x32
// multiply and the one read port of each element store set that rate. Items wait in a four-deep
// command queue and results in a four-deep result queue, so either side may stall without
// stopping the other.
// Element stores hold no reset value: read only entries that have been loaded.
module dense_matrix_multiply_core #(
  parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [4:0]         cfg_data,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         func,
  input  logic [3:0]         row_index,
  input  logic [3:0]         col_index,
  input  logic signed [31:0] element_value,
  output logic               empty,
  input  logic               pop,
  output logic [3:0]         out_row,
  output logic [3:0]         out_col,
  output logic signed [31:0] out_value,
  output logic               last_of_row,
  output logic               index_error
);
  import dmm_pkg::*;

  dims_t dims;
  cmd_t  cmd_in;
  cmd_t  cmd_out;
  res_t  res_in;
  res_t  res_out;
  logic  cmd_push;
  logic  cmd_pop;
  logic  cmd_empty;
  logic  res_push;
  logic  res_pop;

  dmm_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .func         (func),
    .row_index    (row_index),
    .col_index    (col_index),
    .element_value(element_value),
    .cmd_full     (full),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in),
    .dims         (dims)
  );

  dmm_fifo #(
    .W    ($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .wr   (cmd_push),
    .din  (cmd_in),
    .rd   (cmd_pop),
    .dout (cmd_out),
    .full (full),
    .empty(cmd_empty)
  );

  dmm_back #(
    .MAX_DIM(MAX_DIM)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .dims     (dims),
    .cmd      (cmd_out),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .res_push (res_push),
    .res      (res_in),
    .res_pop  (res_pop)
  );

  assign res_pop = pop && !empty;

  // the result queue never overflows: the back end holds one credit per queued beat
  dmm_fifo #(
    .W    ($bits(res_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .wr   (res_push),
    .din  (res_in),
    .rd   (res_pop),
    .dout (res_out),
    .full (),
    .empty(empty)
  );

  assign out_row     = res_out.row;
  assign out_col     = res_out.col;
  assign out_value   = res_out.value;
  assign last_of_row = res_out.last;
  assign index_error = res_out.err;

endmodule

[tb/testbench.sv]
// self-checking bench for the dense matrix multiply core: directed table, then random phases
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dmm_pkg::*;

  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam logic [1:0] REG_UNUSED   = 2'd3;
  localparam int         DIM          = MAX_DIM_DEFAULT;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         CYCLE_LIMIT  = 1000000;
  localparam int         RAND_ITEMS   = 320;
  localparam int         MAX_REPORTS  = 10;
  localparam longint     ACC_MAX      = 64'sh7fffffffffffffff;
  localparam longint     ACC_MIN      = -ACC_MAX - 64'sd1;
  localparam longint     Q16_MAX      = 64'sd2147483647;
  localparam longint     Q16_MIN      = -64'sd2147483648;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [4:0]         cfg_data = '0;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         func = '0;
  logic [3:0]         row_index = '0;
  logic [3:0]         col_index = '0;
  logic signed [31:0] element_value = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [3:0]         out_row;
  logic [3:0]         out_col;
  logic signed [31:0] out_value;
  logic               last_of_row;
  logic               index_error;

  dense_matrix_multiply_core u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [VAL_W-1:0] mat_a [DIM][DIM];
  logic [VAL_W-1:0] mat_b [DIM][DIM];
  logic [DIM_W-1:0] cfg_rows = DIM_RESET;
  logic [DIM_W-1:0] cfg_inner = DIM_RESET;
  logic [DIM_W-1:0] cfg_cols = DIM_RESET;
  res_t             result_elems_q [$];

  // stimulus side bookkeeping
  bit   a_loaded [DIM][DIM];
  bit   b_loaded [DIM][DIM];
  int   gen_nr = 16;
  int   gen_nk = 16;
  int   gen_nc = 16;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   typed_pending = 1'b0;
  res_t typed_beat;
  int   items_sent = 0;
  int   fail_count = 0;
  int   cycle_count = 0;

  typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;
  typedef struct {
    step_kind_t  kind;
    logic [1:0]  f;
    logic [3:0]  r;
    logic [3:0]  c;
    logic [31:0] v;
    logic [4:0]  rows;
    logic [4:0]  inner;
    logic [4:0]  cols;
    bit          typed;
    res_t        want;
  } step_t;
  step_t directed_steps [$];

  function automatic int eff_dim(logic [DIM_W-1:0] v);
    int d;
    d = int'(v);
    if (d > DIM) d = DIM;
    if (d > IDX_REACH) d = IDX_REACH;
    return d;
  endfunction

  function automatic longint sat_acc(longint a, longint b);
    if (b > 0 && a > ACC_MAX - b) return ACC_MAX;
    if (b < 0 && a < ACC_MIN - b) return ACC_MIN;
    return a + b;
  endfunction

  // q32.32 sum to q16.16, round half toward plus infinity, saturate
  function automatic logic [VAL_W-1:0] round_to_q16(longint acc);
    longint q;
    q = acc >>> 16;
    if (acc[15]) q = q + 1;
    if (q > Q16_MAX) q = Q16_MAX;
    if (q < Q16_MIN) q = Q16_MIN;
    return q[31:0];
  endfunction

  function automatic res_t beat(logic [3:0] r, logic [3:0] c, logic [31:0] v, logic l, logic e);
    res_t b;
    b.row = r;
    b.col = c;
    b.value = v;
    b.last = l;
    b.err = e;
    return b;
  endfunction

  task automatic predict_products(input logic [1:0] f, input logic [3:0] r, input logic [3:0] c,
                                  input logic [31:0] v);
    int     nr;
    int     nk;
    int     nc;
    longint acc;
    longint prod;
    res_t   err_beat;
    nr = eff_dim(cfg_rows);
    nk = eff_dim(cfg_inner);
    nc = eff_dim(cfg_cols);
    err_beat = beat(r, c, '0, 1'b1, 1'b1);
    case (f)
      FUNC_LOAD_A: begin
        if (int'(r) >= nr || int'(c) >= nk) result_elems_q.push_back(err_beat);
        else mat_a[r][c] = v;
      end
      FUNC_LOAD_B: begin
        if (int'(r) >= nk || int'(c) >= nc) result_elems_q.push_back(err_beat);
        else mat_b[r][c] = v;
      end
      FUNC_ROW: begin
        if (int'(r) >= nr || nc == 0) begin
          result_elems_q.push_back(err_beat);
        end else begin
          for (int j = 0; j < nc; j++) begin
            acc = 0;
            for (int k = 0; k < nk; k++) begin
              prod = longint'(signed'(mat_a[r][k])) * longint'(signed'(mat_b[k][j]));
              acc = sat_acc(acc, prod);
            end
            result_elems_q.push_back(beat(r, 4'(j), round_to_q16(acc), j == nc - 1, 1'b0));
          end
        end
      end
      default: ;
    endcase
  endtask

  // predictor and checker, both on the rising edge
  always @(posedge clk) begin
    int   n_before;
    res_t want;
    if (!rst) begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ROWS_A:    cfg_rows = cfg_data;
          REG_INNER_DIM: cfg_inner = cfg_data;
          REG_COLS_B:    cfg_cols = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        n_before = result_elems_q.size();
        predict_products(func, row_index, col_index, element_value);
        // a table row with its result written out replaces the predicted one
        if (typed_pending) begin
          while (result_elems_q.size() > n_before) void'(result_elems_q.pop_back());
          result_elems_q.push_back(typed_beat);
        end
      end
      if (pop && !empty) begin
        if (result_elems_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected beat: row %0d col %0d value %h last %b err %b",
                     out_row, out_col, out_value, last_of_row, index_error);
        end else begin
          want = result_elems_q.pop_front();
          if (out_row !== want.row || out_col !== want.col || out_value !== want.value ||
              last_of_row !== want.last || index_error !== want.err) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("mismatch: expected row %0d col %0d value %h last %b err %b",
                       want.row, want.col, want.value, want.last, want.err);
              $display("          got      row %0d col %0d value %h last %b err %b",
                       out_row, out_col, out_value, last_of_row, index_error);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[dense_matrix_multiply_core] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    pop = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic logic [31:0] rand_value();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    case (pick)
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2:       return 32'h00000000;
      3:       return 32'hffffffff;
      4, 5:    return $urandom;
      6, 7, 8, 9, 10, 11: return 32'(signed'(17'($urandom)));
      default: return 32'(signed'(21'($urandom)));
    endcase
  endfunction

  function automatic logic [4:0] pick_dim();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    case (pick)
      0:       return 5'd0;
      1:       return 5'd16;
      2:       return 5'($urandom_range(17, 31));
      3:       return 5'd31;
      4, 5:    return 5'($urandom_range(5, 15));
      default: return 5'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic void add_item(logic [1:0] f, logic [3:0] r, logic [3:0] c, logic [31:0] v,
                                   bit typed = 1'b0, res_t want = '0);
    step_t s;
    s.kind = STEP_ITEM;
    s.f = f;
    s.r = r;
    s.c = c;
    s.v = v;
    s.rows = '0;
    s.inner = '0;
    s.cols = '0;
    s.typed = typed;
    s.want = want;
    directed_steps.push_back(s);
  endfunction

  function automatic void add_cfg(logic [4:0] rows, logic [4:0] inner, logic [4:0] cols);
    step_t s;
    s.kind = STEP_CFG;
    s.f = '0;
    s.r = '0;
    s.c = '0;
    s.v = '0;
    s.rows = rows;
    s.inner = inner;
    s.cols = cols;
    s.typed = 1'b0;
    s.want = '0;
    directed_steps.push_back(s);
  endfunction

  task automatic set_pressure(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
      default: begin send_idle_pct = 11; recv_stall_pct = 11; end
    endcase
  endtask

  // called and returns at a falling edge
  task automatic send_item(logic [1:0] f, logic [3:0] r, logic [3:0] c, logic [31:0] v,
                           bit has_typed, res_t want);
    bit taken;
    typed_pending = has_typed;
    typed_beat = want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    func = f;
    row_index = r;
    col_index = c;
    element_value = v;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !full;
      @(negedge clk);
    end
    typed_pending = 1'b0;
    items_sent++;
  endtask

  // a row product must only touch loaded elements, so missing ones are loaded first
  task automatic emit(logic [1:0] f, logic [3:0] r, logic [3:0] c, logic [31:0] v,
                      bit has_typed = 1'b0, res_t want = '0);
    if (f == FUNC_ROW && int'(r) < gen_nr && gen_nc > 0) begin
      for (int k = 0; k < gen_nk; k++) begin
        if (!a_loaded[r][k]) begin
          send_item(FUNC_LOAD_A, r, 4'(k), rand_value(), 1'b0, '0);
          a_loaded[r][k] = 1'b1;
        end
        for (int j = 0; j < gen_nc; j++) begin
          if (!b_loaded[k][j]) begin
            send_item(FUNC_LOAD_B, 4'(k), 4'(j), rand_value(), 1'b0, '0);
            b_loaded[k][j] = 1'b1;
          end
        end
      end
    end
    if (f == FUNC_LOAD_A && int'(r) < gen_nr && int'(c) < gen_nk) a_loaded[r][c] = 1'b1;
    if (f == FUNC_LOAD_B && int'(r) < gen_nk && int'(c) < gen_nc) b_loaded[r][c] = 1'b1;
    send_item(f, r, c, v, has_typed, want);
  endtask

  // loads give no beat, so let the command queue run dry before touching registers
  task automatic wait_idle();
    push = 1'b0;
    while (result_elems_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic configure(logic [4:0] rows, logic [4:0] inner, logic [4:0] cols, bit poke_unused);
    wait_idle();
    cfg_write = 1'b1;
    cfg_index = REG_ROWS_A;
    cfg_data = rows;
    @(negedge clk);
    cfg_index = REG_INNER_DIM;
    cfg_data = inner;
    @(negedge clk);
    cfg_index = REG_COLS_B;
    cfg_data = cols;
    @(negedge clk);
    if (poke_unused) begin
      cfg_index = REG_UNUSED;
      cfg_data = 5'($urandom);
      @(negedge clk);
    end
    cfg_write = 1'b0;
    gen_nr = eff_dim(rows);
    gen_nk = eff_dim(inner);
    gen_nc = eff_dim(cols);
  endtask

  initial begin
    int          phase;
    logic [3:0]  r;
    logic [1:0]  f;
    add_item(FUNC_LOAD_A, 4'd15, 4'd15, 32'h7fffffff);
    add_item(FUNC_LOAD_B, 4'd15, 4'd15, 32'h80000000);
    add_item(FUNC_UNUSED, 4'd15, 4'd15, 32'hffffffff);
    add_cfg(5'd1, 5'd1, 5'd1);
    add_item(FUNC_LOAD_A, 4'd0, 4'd0, 32'h00010000);
    add_item(FUNC_LOAD_B, 4'd0, 4'd0, 32'h00020000);
    add_item(FUNC_ROW, 4'd0, 4'd9, 32'h0, 1'b1, beat(4'd0, 4'd0, 32'h00020000, 1'b1, 1'b0));
    add_item(FUNC_ROW, 4'd1, 4'd5, 32'h0, 1'b1, beat(4'd1, 4'd5, 32'h0, 1'b1, 1'b1));
    add_item(FUNC_LOAD_A, 4'd0, 4'd1, 32'h1234, 1'b1, beat(4'd0, 4'd1, 32'h0, 1'b1, 1'b1));
    add_item(FUNC_LOAD_B, 4'd0, 4'd15, 32'h5678, 1'b1, beat(4'd0, 4'd15, 32'h0, 1'b1, 1'b1));
    add_item(FUNC_LOAD_A, 4'd0, 4'd0, 32'h7fffffff);
    add_item(FUNC_LOAD_B, 4'd0, 4'd0, 32'h7fffffff);
    add_item(FUNC_ROW, 4'd0, 4'd0, 32'h0, 1'b1, beat(4'd0, 4'd0, 32'h7fffffff, 1'b1, 1'b0));
    add_item(FUNC_LOAD_B, 4'd0, 4'd0, 32'h80000000);
    add_item(FUNC_ROW, 4'd0, 4'd15, 32'h0, 1'b1, beat(4'd0, 4'd0, 32'h80000000, 1'b1, 1'b0));
    // half an lsb either side of zero
    add_item(FUNC_LOAD_A, 4'd0, 4'd0, 32'h00008000);
    add_item(FUNC_LOAD_B, 4'd0, 4'd0, 32'h00000001);
    add_item(FUNC_ROW, 4'd0, 4'd2, 32'h0);
    add_item(FUNC_LOAD_B, 4'd0, 4'd0, 32'hffffffff);
    add_item(FUNC_ROW, 4'd0, 4'd4, 32'h0);
    add_cfg(5'd1, 5'd0, 5'd1);
    add_item(FUNC_ROW, 4'd0, 4'd3, 32'h0, 1'b1, beat(4'd0, 4'd0, 32'h0, 1'b1, 1'b0));
    add_cfg(5'd1, 5'd1, 5'd0);
    add_item(FUNC_ROW, 4'd0, 4'd7, 32'h0, 1'b1, beat(4'd0, 4'd7, 32'h0, 1'b1, 1'b1));
    // two max products overflow the 64-bit accumulator
    add_cfg(5'd1, 5'd2, 5'd1);
    add_item(FUNC_LOAD_A, 4'd0, 4'd0, 32'h80000000);
    add_item(FUNC_LOAD_A, 4'd0, 4'd1, 32'h80000000);
    add_item(FUNC_LOAD_B, 4'd0, 4'd0, 32'h80000000);
    add_item(FUNC_LOAD_B, 4'd1, 4'd0, 32'h80000000);
    add_item(FUNC_ROW, 4'd0, 4'd0, 32'h0, 1'b1, beat(4'd0, 4'd0, 32'h7fffffff, 1'b1, 1'b0));

    repeat (9) @(negedge clk);
    rst = 1'b0;
    set_pressure(0);
    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_CFG)
        configure(directed_steps[i].rows, directed_steps[i].inner, directed_steps[i].cols, 1'b0);
      else
        emit(directed_steps[i].f, directed_steps[i].r, directed_steps[i].c, directed_steps[i].v,
             directed_steps[i].typed, directed_steps[i].want);
    end

    items_sent = 0;
    phase = 0;
    while (items_sent < RAND_ITEMS) begin
      configure(pick_dim(), pick_dim(), pick_dim(), $urandom_range(0, 3) == 0);
      set_pressure(phase % 4);
      repeat ($urandom_range(12, 30)) begin
        if ($urandom_range(0, 9) < 7) begin
          // refresh a few elements of one row's operands, then ask for the row
          if (gen_nr > 0) r = 4'($urandom_range(0, gen_nr - 1));
          else r = 4'($urandom_range(0, 15));
          repeat ($urandom_range(0, 3)) begin
            if (gen_nk > 0 && $urandom_range(0, 1) == 0)
              emit(FUNC_LOAD_A, r, 4'($urandom_range(0, gen_nk - 1)), rand_value());
            else if (gen_nk > 0 && gen_nc > 0)
              emit(FUNC_LOAD_B, 4'($urandom_range(0, gen_nk - 1)),
                   4'($urandom_range(0, gen_nc - 1)), rand_value());
          end
          emit(FUNC_ROW, r, 4'($urandom_range(0, 15)), $urandom);
        end else begin
          f = 2'($urandom_range(0, 3));
          emit(f, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), $urandom);
        end
      end
      phase++;
    end

    wait_idle();
    if (fail_count == 0 && result_elems_q.size() == 0)
      $display("[dense_matrix_multiply_core] OK");
    else
      $display("[dense_matrix_multiply_core] ERROR");
    $finish;
  end

endmodule
